### hdl/wscfv_pkg.sv
package wscfv_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CountW = 7;
  localparam int unsigned CodeW = 16;
  localparam int unsigned RespW = 13;
  localparam int unsigned CpW = 21;

  localparam logic [CountW-1:0] CountSat = 7'd126;
  localparam logic [CountW-1:0] MaxLen = 7'd125;

  localparam logic [CodeW-1:0] CodeNormal = 16'd1000;
  localparam logic [CodeW-1:0] CodeProtoErr = 16'd1002;
  localparam logic [CodeW-1:0] CodeBadData = 16'd1007;
  localparam logic [CodeW-1:0] CodeStdHigh = 16'd1014;
  localparam logic [CodeW-1:0] CodeRsvNoStatus = 16'd1004;
  localparam logic [CodeW-1:0] CodeRsvNoCode = 16'd1005;
  localparam logic [CodeW-1:0] CodeRsvAbnormal = 16'd1006;
  localparam logic [CodeW-1:0] CodeRsvTls = 16'd1015;
  localparam logic [CodeW-1:0] CodeAppLow = 16'd3000;
  localparam logic [CodeW-1:0] CodeAppHigh = 16'd4999;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             fin;
    logic             masked;
    logic             first;
    logic             last;
    logic             empty_req;
  } item_t;

  typedef struct packed {
    logic             valid;
    logic             accepted;
    logic [RespW-1:0] response_code;
  } verdict_t;

  typedef struct packed {
    logic [1:0]     pending;
    logic [CpW-1:0] value;
    logic [1:0]     length;
    logic           error;
  } utf8_t;

  function automatic utf8_t utf8_feed(utf8_t s, logic [ByteW-1:0] b);
    utf8_t r;
    r = s;
    if (!s.error) begin
      if (s.pending == 2'd0) begin
        if (b[7] == 1'b0) begin
          r = s;
        end else if (b[7:5] == 3'b110) begin
          r.value = {16'd0, b[4:0]};
          r.pending = 2'd1;
          r.length = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          r.value = {17'd0, b[3:0]};
          r.pending = 2'd2;
          r.length = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          r.value = {18'd0, b[2:0]};
          r.pending = 2'd3;
          r.length = 2'd3;
        end else begin
          r.error = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        r.error = 1'b1;
      end else begin
        r.value = {s.value[CpW-7:0], b[5:0]};
        r.pending = s.pending - 2'd1;
        if (r.pending == 2'd0) begin
          case (s.length)
            2'd1: r.error = (r.value < 21'h80);
            2'd2: r.error = (r.value < 21'h800) ||
                            (r.value >= 21'hD800 && r.value <= 21'hDFFF);
            default: r.error = (r.value < 21'h10000) || (r.value > 21'h10FFFF);
          endcase
        end
      end
    end
    return r;
  endfunction

  function automatic logic code_ok(logic [CodeW-1:0] c);
    logic in_range;
    in_range = (c >= CodeNormal && c <= CodeStdHigh) ||
               (c >= CodeAppLow && c <= CodeAppHigh);
    return in_range && c != CodeRsvNoStatus && c != CodeRsvNoCode &&
           c != CodeRsvAbnormal && c != CodeRsvTls;
  endfunction

endpackage

### hdl/websocket_close_frame_validator.sv
// WebSocket close-frame payload checker.
// Slave channel: one close payload byte per word. s_tdata[7:0] is the byte,
// s_tlast marks the last byte, s_tuser carries fin, masked, first, empty_req.
// A frame with no payload is one word with empty_req set; tdata is ignored.
// Master channel: one word per frame, on the last byte or the empty word,
// m_tdata[0] = accepted, m_tdata[13:1] = response code (1000, echoed code,
// 1002 or 1007).
// The last byte is held in the input register, then the verdict is loaded
// into the result register; while the receiver stalls an earlier result, the
// verdict waits in the input register.
// Throughput: one byte per cycle while no verdict waits in the input register;
// each byte updates the count, close code and UTF-8 decoder state in a single pass.
// Reset (rst, synchronous): both stages empty and all frame state cleared.
// When the receiver stalls, the result word holds and bytes that give no
// verdict keep flowing; the next verdict waits in the input register, and
// s_tready drops only while it waits.
module websocket_close_frame_validator
  import wscfv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // payload_byte[7:0]
  input  logic        s_tlast,   // last
  input  logic [3:0]  s_tuser,   // fin, masked, first, empty_req
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // accepted, response_code[12:0], zero pad
);

  logic     in_valid;
  item_t    in_item;
  logic     adv;
  verdict_t res;
  logic     out_valid;
  logic     out_accepted;
  logic [RespW-1:0] out_code;

  assign adv = in_valid && (!res.valid || !out_valid || m_tready);
  assign s_tready = !in_valid || adv;

  wscfv_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (adv),
    .item (in_item),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (adv) begin
        in_valid <= 1'b0;
      end
      if (adv && res.valid) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (s_tvalid && s_tready) begin
      in_item.payload_byte <= s_tdata;
      in_item.fin <= s_tuser[0];
      in_item.masked <= s_tuser[1];
      in_item.first <= s_tuser[2];
      in_item.last <= s_tlast;
      in_item.empty_req <= s_tuser[3];
    end
    if (adv && res.valid) begin
      out_accepted <= res.accepted;
      out_code <= res.response_code;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {2'b00, out_code, out_accepted};

endmodule

### hdl/wscfv_core.sv
module wscfv_core
  import wscfv_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  item_t    item,
  output verdict_t res
);

  logic [CountW-1:0] byte_count, byte_count_next;
  logic [CodeW-1:0]  close_code, close_code_next;
  utf8_t             utf8, utf8_next;

  logic [CountW-1:0] cnt_base;
  logic [CodeW-1:0]  cc_base;
  utf8_t             utf8_base;
  utf8_t             utf8_fed;
  logic              hdr_ok;
  logic              cc_ok;
  logic              text_bad;

  always_comb begin
    cnt_base = item.first ? '0 : byte_count;
    cc_base = item.first ? '0 : close_code;
    utf8_base = item.first ? '0 : utf8;
    utf8_fed = utf8_feed(utf8_base, item.payload_byte);

    close_code_next = cc_base;
    utf8_next = utf8_base;
    if (cnt_base == '0) begin
      close_code_next = {item.payload_byte, 8'd0};
    end else if (cnt_base == CountW'(1)) begin
      close_code_next = {cc_base[15:8], item.payload_byte};
    end else begin
      utf8_next = utf8_fed;
    end
    byte_count_next = (cnt_base < CountSat) ? cnt_base + CountW'(1) : cnt_base;

    hdr_ok = item.fin && item.masked && byte_count_next <= MaxLen &&
             byte_count_next != CountW'(1);
    cc_ok = code_ok(close_code_next);
    text_bad = byte_count_next > CountW'(2) &&
               (utf8_next.error || utf8_next.pending != 2'd0);

    res.valid = item.last || item.empty_req;
    if (item.empty_req) begin
      res.accepted = item.fin && item.masked;
      res.response_code = res.accepted ? CodeNormal[RespW-1:0] : CodeProtoErr[RespW-1:0];
    end else if (!hdr_ok || !cc_ok) begin
      res.accepted = 1'b0;
      res.response_code = CodeProtoErr[RespW-1:0];
    end else if (text_bad) begin
      res.accepted = 1'b0;
      res.response_code = CodeBadData[RespW-1:0];
    end else begin
      res.accepted = 1'b1;
      res.response_code = close_code_next[RespW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      close_code <= '0;
      utf8 <= '0;
    end else if (step) begin
      if (item.empty_req || item.last) begin
        byte_count <= '0;
        close_code <= '0;
        utf8 <= '0;
      end else begin
        byte_count <= byte_count_next;
        close_code <= close_code_next;
        utf8 <= utf8_next;
      end
    end
  end

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CountSat)
    else $error("byte count above saturation");

  a_pending_len: assert property (@(posedge clk) disable iff (rst)
    utf8.pending <= utf8.length)
    else $error("utf8 pending exceeds sequence length");

  a_clear_after: assert property (@(posedge clk) disable iff (rst)
    step && (item.last || item.empty_req) |=> byte_count == '0 && utf8.pending == 2'd0)
    else $error("frame state not cleared after verdict");

  a_reject_code: assert property (@(posedge clk) disable iff (rst)
    step && res.valid && !res.accepted |->
      res.response_code == CodeProtoErr[RespW-1:0] ||
      res.response_code == CodeBadData[RespW-1:0])
    else $error("reject with unexpected code");

endmodule
